// ===== design/pgpm_pkg.sv =====
// pgpm_pkg: request and result types, codes, microcode program and small helpers
// for the pad grid piano note mapper. Depends on nothing.
package pgpm_pkg;

  typedef struct packed {
    logic       mode;
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] action;
    logic [2:0] button;
    logic [6:0] velocity;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] level;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic       last;
  } rsp_t;

  localparam logic       MODE_PAD     = 1'b0;
  localparam logic       MODE_MENU    = 1'b1;
  localparam logic [1:0] ACT_PRESS    = 2'd0;
  localparam logic [1:0] ACT_RELEASE  = 2'd1;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [2:0] BTN_OCT_UP   = 3'd0;
  localparam logic [2:0] BTN_OCT_DOWN = 3'd1;
  localparam logic [2:0] BTN_TR_UP    = 3'd2;
  localparam logic [2:0] BTN_TR_DOWN  = 3'd3;

  localparam logic [2:0] OCT_RESET    = 3'd4;
  localparam logic [2:0] OCT_MAX      = 3'd7;
  localparam logic [3:0] TR_RESET     = 4'd0;
  localparam logic [3:0] TR_MAX       = 4'd11;
  localparam logic [7:0] NOTE_LIMIT   = 8'd128;
  localparam logic [7:0] NOTE_TOP     = 8'd127;
  localparam logic [2:0] ROW_FIRST    = 3'd7;
  localparam logic [2:0] ROW_LAST     = 3'd1;
  localparam logic [2:0] COL_LAST     = 3'd6;
  localparam logic [5:0] CELL_LAST    = 6'd63;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_BINIT,
    OP_BWHITE,
    OP_BBLACK,
    OP_BSTEP,
    OP_LATCH,
    OP_DECODE,
    OP_SINIT,
    OP_STEST,
    OP_SEMIT,
    OP_SNEXT,
    OP_COMMIT,
    OP_PREAD,
    OP_PEMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_PAD_HIT,
    C_NO_CHANGE,
    C_NO_HIT,
    C_OUT_BUSY,
    C_MORE_CELLS,
    C_MORE_KEYS
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic req;
    logic pad_hit;
    logic no_change;
    logic no_hit;
    logic out_busy;
    logic more_cells;
    logic more_keys;
  } status_t;

  localparam upc_t PC_BUILD = 4'd0;
  localparam upc_t PC_BWHITE = 4'd1;
  localparam upc_t PC_IDLE  = 4'd4;
  localparam upc_t PC_STEST = 4'd8;
  localparam upc_t PC_SEMIT = 4'd9;
  localparam upc_t PC_SNEXT = 4'd10;
  localparam upc_t PC_PREAD = 4'd12;
  localparam upc_t PC_PEMIT = 4'd13;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_BINIT,  C_NEXT,       PC_BUILD};
      4'd1:    w = '{OP_BWHITE, C_NEXT,       PC_BUILD};
      4'd2:    w = '{OP_BBLACK, C_NEXT,       PC_BUILD};
      4'd3:    w = '{OP_BSTEP,  C_MORE_KEYS,  PC_BWHITE};
      4'd4:    w = '{OP_LATCH,  C_NO_REQ,     PC_IDLE};
      4'd5:    w = '{OP_DECODE, C_PAD_HIT,    PC_PREAD};
      4'd6:    w = '{OP_NOP,    C_NO_CHANGE,  PC_IDLE};
      4'd7:    w = '{OP_SINIT,  C_NEXT,       PC_BUILD};
      4'd8:    w = '{OP_STEST,  C_NO_HIT,     PC_SNEXT};
      4'd9:    w = '{OP_SEMIT,  C_OUT_BUSY,   PC_SEMIT};
      4'd10:   w = '{OP_SNEXT,  C_MORE_CELLS, PC_STEST};
      4'd11:   w = '{OP_COMMIT, C_ALWAYS,     PC_BUILD};
      4'd12:   w = '{OP_PREAD,  C_NEXT,       PC_BUILD};
      4'd13:   w = '{OP_PEMIT,  C_OUT_BUSY,   PC_PEMIT};
      4'd14:   w = '{OP_NOP,    C_ALWAYS,     PC_IDLE};
      default: w = '{OP_NOP,    C_ALWAYS,     PC_BUILD};
    endcase
    return w;
  endfunction

  // semitone has a black key right above it
  function automatic logic black_follows(logic [3:0] m);
    return (m == 4'd0) || (m == 4'd2) || (m == 4'd5) || (m == 4'd7) || (m == 4'd9);
  endfunction

  function automatic logic is_black(logic [3:0] m);
    return (m == 4'd1) || (m == 4'd3) || (m == 4'd6) || (m == 4'd8) || (m == 4'd10);
  endfunction

  function automatic logic [3:0] mod12_inc(logic [3:0] m);
    return (m == TR_MAX) ? 4'd0 : 4'(m + 4'd1);
  endfunction

  function automatic logic [3:0] tr_up(logic [3:0] tr);
    logic [3:0] t;
    t = 4'(tr + 4'd1);
    if (t > TR_MAX) begin
      t = TR_RESET;
    end else if (is_black(t)) begin
      t = 4'(t + 4'd1);
    end
    return t;
  endfunction

  function automatic logic [3:0] tr_down(logic [3:0] tr);
    logic [3:0] t;
    if (tr == 4'd0) begin
      t = TR_MAX;
    end else begin
      t = 4'(tr - 4'd1);
      if (is_black(t)) begin
        t = 4'(t - 4'd1);
      end
    end
    return t;
  endfunction

endpackage

// ===== design/pgpm_ram.sv =====
// pgpm_ram: generic single port write, single port read RAM with registered read.
// Standalone, no package dependency.
module pgpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pgpm_useq.sv =====
// pgpm_useq: microcode step counter with conditional jumps.
// Depends on pgpm_pkg for the control word, the program and the status struct.
module pgpm_useq (
  input  logic             clk,
  input  logic             rst,
  input  pgpm_pkg::status_t status,
  output pgpm_pkg::op_t     op
);

  pgpm_pkg::upc_t   pc;
  pgpm_pkg::upc_t   pc_next;
  pgpm_pkg::uword_t uw;
  logic             take;

  assign uw = pgpm_pkg::ucode(pc);
  assign op = uw.op;

  always_comb begin
    case (uw.cond)
      pgpm_pkg::C_NEXT:       take = 1'b0;
      pgpm_pkg::C_ALWAYS:     take = 1'b1;
      pgpm_pkg::C_NO_REQ:     take = !status.req;
      pgpm_pkg::C_PAD_HIT:    take = status.pad_hit;
      pgpm_pkg::C_NO_CHANGE:  take = status.no_change;
      pgpm_pkg::C_NO_HIT:     take = status.no_hit;
      pgpm_pkg::C_OUT_BUSY:   take = status.out_busy;
      pgpm_pkg::C_MORE_CELLS: take = status.more_cells;
      pgpm_pkg::C_MORE_KEYS:  take = status.more_keys;
      default:                take = 1'b0;
    endcase
  end

  assign pc_next = take ? uw.target : pgpm_pkg::upc_t'(pc + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pgpm_pkg::PC_BUILD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== design/pgpm_datapath.sv =====
// pgpm_datapath: settings, cell flags, white key note RAM and result register,
// driven one operation per cycle by the sequencer. Depends on pgpm_pkg, pgpm_ram.
module pgpm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pgpm_pkg::op_t     op,
  output pgpm_pkg::status_t status,
  input  logic              req_valid,
  output logic              req_ready,
  input  pgpm_pkg::req_t    req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output pgpm_pkg::rsp_t    rsp_data
);

  logic [2:0]     oct;
  logic [3:0]     tr;
  logic [3:0]     bdown;
  logic [2:0]     oct_new;
  logic [3:0]     tr_new;
  logic           chg;
  logic [63:0]    has;
  logic [63:0]    held;
  pgpm_pkg::req_t req;
  logic [2:0]     brow;
  logic [2:0]     bcol;
  logic [7:0]     note_acc;
  logic [3:0]     m;
  logic [5:0]     idx;

  logic [7:0]     base;
  logic [5:0]     wcell;
  logic [5:0]     bcell;
  logic [5:0]     pcell;
  logic           ram_we;
  logic [4:0]     ram_raddr;
  logic [6:0]     ram_rdata;
  logic           pad_side;
  logic [2:0]     look_row;
  logic [6:0]     look_note;
  logic           out_busy;
  logic           emit;

  logic           menu_ok;
  logic [3:0]     own;
  logic [3:0]     partner;
  logic [3:0]     bd_pressed;
  logic           both;
  logic [2:0]     oct_calc;
  logic [3:0]     tr_calc;
  logic [63:0]    left_after;

  assign base  = 8'({oct, 3'b000}) + 8'({oct, 2'b00}) + 8'(tr);
  assign wcell = {brow, bcol};
  assign bcell = {3'(brow - 3'd1), bcol};
  assign pcell = {req.row, req.col};

  assign ram_we = (op == pgpm_pkg::OP_BWHITE) && (note_acc < pgpm_pkg::NOTE_LIMIT);

  // black rows read the white key below them, one semitone up
  assign pad_side  = (op == pgpm_pkg::OP_PREAD) || (op == pgpm_pkg::OP_PEMIT);
  assign ram_raddr = pad_side ? {req.row[2:1], req.col} : {idx[5:4], idx[2:0]};
  assign look_row  = pad_side ? req.row : idx[5:3];
  assign look_note = 7'(ram_rdata + {6'd0, !look_row[0]});

  pgpm_ram #(
    .WIDTH(7),
    .DEPTH(32)
  ) u_notes (
    .clk  (clk),
    .we   (ram_we),
    .waddr({brow[2:1], bcol}),
    .wdata(note_acc[6:0]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // menu decode
  always_comb begin
    case (req.button)
      pgpm_pkg::BTN_OCT_UP:   begin own = 4'b0001; partner = 4'b0010; end
      pgpm_pkg::BTN_OCT_DOWN: begin own = 4'b0010; partner = 4'b0001; end
      pgpm_pkg::BTN_TR_UP:    begin own = 4'b1000; partner = 4'b0100; end
      pgpm_pkg::BTN_TR_DOWN:  begin own = 4'b0100; partner = 4'b1000; end
      default:                begin own = 4'b0000; partner = 4'b0000; end
    endcase
  end

  assign menu_ok    = (req.mode == pgpm_pkg::MODE_MENU) && !req.button[2];
  assign bd_pressed = bdown | own;
  assign both       = |(bd_pressed & partner);

  always_comb begin
    oct_calc = oct;
    tr_calc  = tr;
    if (both) begin
      if (req.button[1]) begin
        tr_calc = pgpm_pkg::TR_RESET;
      end else begin
        oct_calc = pgpm_pkg::OCT_RESET;
      end
    end else begin
      case (req.button)
        pgpm_pkg::BTN_OCT_UP: begin
          if (oct != pgpm_pkg::OCT_MAX) oct_calc = 3'(oct + 3'd1);
        end
        pgpm_pkg::BTN_OCT_DOWN: begin
          if (oct != 3'd0) oct_calc = 3'(oct - 3'd1);
        end
        pgpm_pkg::BTN_TR_UP:   tr_calc = pgpm_pkg::tr_up(tr);
        pgpm_pkg::BTN_TR_DOWN: tr_calc = pgpm_pkg::tr_down(tr);
        default: begin
          oct_calc = oct;
          tr_calc  = tr;
        end
      endcase
    end
  end

  assign left_after = has & held & ~(64'd1 << idx);

  assign out_busy  = rsp_valid && !rsp_ready;
  assign emit      = ((op == pgpm_pkg::OP_SEMIT) || (op == pgpm_pkg::OP_PEMIT)) && !out_busy;
  assign req_ready = (op == pgpm_pkg::OP_LATCH);

  assign status.req        = req_valid;
  assign status.pad_hit    = (req.mode == pgpm_pkg::MODE_PAD) && has[pcell]
                             && (req.action != pgpm_pkg::ACT_UNUSED);
  assign status.no_change  = !chg;
  assign status.no_hit     = !(has[idx] && held[idx]);
  assign status.out_busy   = out_busy;
  assign status.more_cells = (idx != pgpm_pkg::CELL_LAST);
  assign status.more_keys  = !((brow == pgpm_pkg::ROW_LAST) && (bcol == pgpm_pkg::COL_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      oct       <= pgpm_pkg::OCT_RESET;
      tr        <= pgpm_pkg::TR_RESET;
      bdown     <= 4'd0;
      chg       <= 1'b0;
      has       <= '0;
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (op)
        pgpm_pkg::OP_BINIT: begin
          has  <= '0;
          held <= '0;
        end
        pgpm_pkg::OP_BWHITE: begin
          if (note_acc < pgpm_pkg::NOTE_LIMIT) has[wcell] <= 1'b1;
        end
        pgpm_pkg::OP_BBLACK: begin
          if (note_acc < pgpm_pkg::NOTE_TOP && pgpm_pkg::black_follows(m)) has[bcell] <= 1'b1;
        end
        pgpm_pkg::OP_DECODE: begin
          chg <= 1'b0;
          if (menu_ok && req.action == pgpm_pkg::ACT_PRESS) begin
            bdown <= bd_pressed;
            chg   <= (oct_calc != oct) || (tr_calc != tr);
          end else if (menu_ok && req.action == pgpm_pkg::ACT_RELEASE) begin
            bdown <= bdown & ~own;
          end
        end
        pgpm_pkg::OP_SEMIT: begin
          if (!out_busy) held[idx] <= 1'b0;
        end
        pgpm_pkg::OP_PEMIT: begin
          if (!out_busy) held[pcell] <= (req.action != pgpm_pkg::ACT_RELEASE);
        end
        pgpm_pkg::OP_COMMIT: begin
          oct <= oct_new;
          tr  <= tr_new;
        end
        default: begin
          chg <= chg;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      pgpm_pkg::OP_BINIT: begin
        note_acc <= base;
        m        <= tr;
        brow     <= pgpm_pkg::ROW_FIRST;
        bcol     <= 3'd0;
      end
      pgpm_pkg::OP_BBLACK: begin
        if (note_acc < pgpm_pkg::NOTE_TOP && pgpm_pkg::black_follows(m)) begin
          note_acc <= 8'(note_acc + 8'd1);
          m        <= pgpm_pkg::mod12_inc(m);
        end
      end
      pgpm_pkg::OP_BSTEP: begin
        note_acc <= 8'(note_acc + 8'd1);
        m        <= pgpm_pkg::mod12_inc(m);
        if (bcol == pgpm_pkg::COL_LAST) begin
          bcol <= 3'd0;
          brow <= 3'(brow - 3'd2);
        end else begin
          bcol <= 3'(bcol + 3'd1);
        end
      end
      pgpm_pkg::OP_LATCH: begin
        if (req_valid) req <= req_data;
      end
      pgpm_pkg::OP_DECODE: begin
        oct_new <= oct_calc;
        tr_new  <= tr_calc;
      end
      pgpm_pkg::OP_SINIT: begin
        idx <= 6'd0;
      end
      pgpm_pkg::OP_SNEXT: begin
        idx <= 6'(idx + 6'd1);
      end
      pgpm_pkg::OP_SEMIT: begin
        if (!out_busy) begin
          rsp_data.kind     <= pgpm_pkg::KIND_STOP;
          rsp_data.note     <= look_note;
          rsp_data.level    <= 7'd0;
          rsp_data.cell_row <= idx[5:3];
          rsp_data.cell_col <= idx[2:0];
          rsp_data.last     <= (left_after == 64'd0);
        end
      end
      pgpm_pkg::OP_PEMIT: begin
        if (!out_busy) begin
          rsp_data.kind     <= req.action;
          rsp_data.note     <= look_note;
          rsp_data.level    <= (req.action == pgpm_pkg::ACT_RELEASE) ? 7'd0 : req.velocity;
          rsp_data.cell_row <= req.row;
          rsp_data.cell_col <= req.col;
          rsp_data.last     <= 1'b1;
        end
      end
      default: begin
        m <= m;
      end
    endcase
  end

endmodule

// ===== design/pad_grid_piano_note_mapper.sv =====
// pad_grid_piano_note_mapper: top level, sequencer plus datapath.
// Depends on pgpm_pkg, pgpm_useq, pgpm_datapath.
//
// Requests come in on req_valid/req_ready/req_data (pad or menu button events);
// results leave on rsp_valid/rsp_ready/rsp_data, with last set on the final
// result of a request. One request is worked at a time by a microcoded sequencer.
// After reset the layout for octave 4, transpose 0 is built before req_ready
// first rises, in one pass over the 28 white keys with a white note, a black
// note and a next key step each. A pad event on a note cell goes through the
// latch, decode, note read and emit steps; its result is registered in the
// emit step. A menu event with no effect, or a pad event that hits no note,
// goes back to the latch step after decode. A setting change scans all 64
// cells, a test and a next step per cell plus an emit step for a held cell,
// then commits the new settings and rebuilds the layout.
// Results sit in one output register; while the receiver stalls the sequencer
// waits on that register and no work or request is lost.
module pad_grid_piano_note_mapper (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pgpm_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pgpm_pkg::rsp_t rsp_data
);

  pgpm_pkg::op_t     op;
  pgpm_pkg::status_t status;

  pgpm_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .op    (op)
  );

  pgpm_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .status   (status),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

endmodule
